/* rtl/clrd_pkg.sv */
package clrd_pkg;

  // packet control byte fields
  localparam logic [7:0] COUNT_MASK = 8'h7f;
  localparam logic [7:0] RUN_FLAG   = 8'h80;

  // line total after reset
  localparam logic [15:0] LINE_TOTAL_RESET = 16'd1;

  // one compressed body byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_mark;
  } in_item_t;

  // one decoded run, literal or status
  typedef struct packed {
    logic [7:0] pixel_value;
    logic [6:0] repeat_count;
    logic       line_done;
    logic       image_done;
    logic       format_error;
  } out_item_t;

endpackage

/* rtl/clrd_core.sv */
module clrd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr,
  input  logic [15:0]        cfg_value,
  input  logic               step_en,
  input  clrd_pkg::in_item_t item,
  output logic               res_valid,
  output clrd_pkg::out_item_t res
);
  import clrd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_CTRL    = 3'd3,
    PH_RUN_VAL = 3'd4,
    PH_LITERAL = 3'd5,
    PH_ERROR   = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [15:0] lbl_r, lbl_nxt, lbl_eff, lbl_dec;
  logic [7:0]  hold_r, hold_nxt;
  logic [6:0]  lit_r, lit_nxt, lit_eff, lit_dec, cnt;
  logic [15:0] idx_r, idx_nxt, idx_eff, idx_inc;
  logic [15:0] line_total_r;
  logic        last;
  logic        do_end;
  logic [7:0]  end_val;
  logic [6:0]  end_rep;

  // start mark restarts the decoder before the byte is used
  always_comb begin
    phase_eff = item.start_mark ? PH_LEN_LO : phase_r;
    idx_eff   = item.start_mark ? 16'd0 : idx_r;
    lit_eff   = item.start_mark ? 7'd0 : lit_r;
    lbl_eff   = item.start_mark ? 16'd0 : lbl_r;
    lbl_dec   = lbl_eff - 16'd1;
    lit_dec   = lit_eff - 7'd1;
    idx_inc   = idx_eff + 16'd1;
    last      = (idx_inc == line_total_r);
    cnt       = item.data_byte[6:0] & COUNT_MASK[6:0];
  end

  // per-byte state update and result
  always_comb begin
    phase_nxt = phase_eff;
    lbl_nxt   = lbl_eff;
    hold_nxt  = hold_r;
    lit_nxt   = lit_eff;
    idx_nxt   = idx_eff;
    res_valid = 1'b0;
    res       = '0;
    do_end    = 1'b0;
    end_val   = 8'd0;
    end_rep   = 7'd0;
    unique case (phase_eff)
      PH_LEN_LO: begin
        hold_nxt  = item.data_byte;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        lbl_nxt = {item.data_byte, hold_r};
        if ({item.data_byte, hold_r} == 16'd0) begin
          do_end = 1'b1;
        end else begin
          phase_nxt = PH_CTRL;
        end
      end
      PH_CTRL: begin
        lbl_nxt = lbl_dec;
        if (cnt == 7'd0) begin
          if (lbl_dec == 16'd0) begin
            do_end = 1'b1;
          end
        end else if (lbl_dec == 16'd0) begin
          phase_nxt          = PH_ERROR;
          res_valid          = 1'b1;
          res.format_error   = 1'b1;
        end else begin
          lit_nxt   = cnt;
          phase_nxt = ((item.data_byte & RUN_FLAG) != 8'd0) ? PH_RUN_VAL : PH_LITERAL;
        end
      end
      PH_RUN_VAL: begin
        lbl_nxt = lbl_dec;
        lit_nxt = 7'd0;
        if (lbl_dec == 16'd0) begin
          do_end  = 1'b1;
          end_val = item.data_byte;
          end_rep = lit_eff;
        end else begin
          phase_nxt        = PH_CTRL;
          res_valid        = 1'b1;
          res.pixel_value  = item.data_byte;
          res.repeat_count = lit_eff;
        end
      end
      PH_LITERAL: begin
        lbl_nxt = lbl_dec;
        lit_nxt = lit_dec;
        if (lit_dec != 7'd0) begin
          res_valid        = 1'b1;
          res.pixel_value  = item.data_byte;
          res.repeat_count = 7'd1;
          if (lbl_dec == 16'd0) begin
            phase_nxt        = PH_ERROR;
            res.format_error = 1'b1;
          end
        end else if (lbl_dec == 16'd0) begin
          do_end  = 1'b1;
          end_val = item.data_byte;
          end_rep = 7'd1;
        end else begin
          phase_nxt        = PH_CTRL;
          res_valid        = 1'b1;
          res.pixel_value  = item.data_byte;
          res.repeat_count = 7'd1;
        end
      end
      PH_IDLE, PH_ERROR, PH_DONE: begin
      end
      default: begin
      end
    endcase
    // line completion
    if (do_end) begin
      idx_nxt          = idx_inc;
      phase_nxt        = last ? PH_DONE : PH_LEN_LO;
      res_valid        = 1'b1;
      res.pixel_value  = end_val;
      res.repeat_count = end_rep;
      res.line_done    = 1'b1;
      res.image_done   = last;
    end
  end

  // decoder state and line total register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      lbl_r        <= 16'd0;
      hold_r       <= 8'd0;
      lit_r        <= 7'd0;
      idx_r        <= 16'd0;
      line_total_r <= LINE_TOTAL_RESET;
    end else begin
      if (cfg_wr) begin
        line_total_r <= cfg_value;
      end
      if (step_en) begin
        phase_r <= phase_nxt;
        lbl_r   <= lbl_nxt;
        hold_r  <= hold_nxt;
        lit_r   <= lit_nxt;
        idx_r   <= idx_nxt;
      end
    end
  end

endmodule

/* rtl/clrd_out_buf.sv */
module clrd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  clrd_pkg::out_item_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output clrd_pkg::out_item_t out_data
);
  import clrd_pkg::*;

  out_item_t   head_r, tail_r;
  logic [1:0]  cnt_r;
  logic        pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_data  = head_r;

  // two-entry result queue: output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      if (push && pop) begin
        if (cnt_r == 2'd1) begin
          head_r <= push_data;
        end else begin
          head_r <= tail_r;
          tail_r <= push_data;
        end
      end else if (push) begin
        if (cnt_r == 2'd0) begin
          head_r <= push_data;
        end else begin
          tail_r <= push_data;
        end
        cnt_r <= cnt_r + 2'd1;
      end else if (pop) begin
        head_r <= tail_r;
        cnt_r  <= cnt_r - 2'd1;
      end
    end
  end

endmodule

/* rtl/cut_line_rle_decoder.sv */
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall   | in_data (in_item_t)
// out_    | output    | out_valid / out_stall | out_data (out_item_t)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_data (line total)
//
// One byte per cycle while the result queue has room: a byte is held in the input
// register, is decoded there and its result is registered in the output queue.
// Synchronous active-low reset returns the decoder to idle, awaiting a start mark,
// with a line total of one.
// A stalled output fills the two-entry result queue; in_stall rises only when
// the queue is full and a byte is waiting in the input register.
module cut_line_rle_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clrd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output clrd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import clrd_pkg::*;

  in_item_t  item_r;
  logic      item_valid_r;
  logic      advance;
  logic      q_full;
  logic      res_valid;
  out_item_t res;

  assign advance   = item_valid_r && !q_full;
  assign in_stall  = item_valid_r && q_full;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
      item_r       <= in_data;
    end
  end

  // byte decode and state
  clrd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .step_en   (advance),
    .item      (item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue
  clrd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance && res_valid),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
